// ===== hw/rtl/eoq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eoq_pkg
// Shared types and codes for the ordered event queue: channel payloads,
// controller states, and the command and status groups between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package eoq_pkg;

  localparam int unsigned RspTickW = 32;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_POP    = 1'b1
  } eoq_action_t;

  typedef enum logic [1:0] {
    RES_INSERTED = 2'd0,
    RES_POPPED   = 2'd1,
    RES_EMPTY    = 2'd2,
    RES_FULL     = 2'd3
  } eoq_status_t;

  typedef struct packed {
    eoq_action_t  action;
    logic [7:0]   event_number;
    logic [31:0]  deadline;
    logic [31:0]  stamp;
    logic [3:0]   micro_step;
    logic [7:0]   level;
  } eoq_req_t;

  typedef struct packed {
    eoq_status_t  status;
    logic [7:0]   head_event_number;
    logic [31:0]  head_deadline;
    logic [31:0]  head_stamp;
    logic [3:0]   head_micro_step;
    logic [7:0]   head_level;
    logic [4:0]   occupancy;
  } eoq_rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_CMP,
    S_PLACE,
    S_POP_WAIT,
    S_RESULT
  } eoq_state_t;

  typedef struct packed {
    logic        latch_in;   // capture the accepted request
    logic        rd_head;    // read the head entry
    logic        rd_start;   // start an insert walk at the tail
    logic        shift;      // move the read entry up one place
    logic        place;      // write the new entry at the walk position
    logic        pop_take;   // take the head entry as the result
    logic        set_res;    // set a result with no entry fields
    eoq_status_t res_code;
    logic        load_out;   // move the result into the output register
  } eoq_cmd_t;

  typedef struct packed {
    logic is_pop;
    logic empty;
    logic full;
    logic new_less;  // new tag strictly below the entry just read
    logic walk_last; // walk position is one, so the next shift ends the walk
    logic out_free;
  } eoq_stat_t;

endpackage

// ===== hw/rtl/eoq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eoq_ctrl
// Controller for the ordered event queue. Sequences one request at a time:
// decides the case, steps the insert walk and hands the result to the
// output register.
// ----------------------------------------------------------------------------
module eoq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  eoq_pkg::eoq_stat_t stat,
  output eoq_pkg::eoq_cmd_t  cmd
);
  import eoq_pkg::*;

  eoq_state_t state;
  eoq_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (stat.is_pop) begin
          state_next = stat.empty ? S_RESULT : S_POP_WAIT;
        end else if (stat.full) begin
          state_next = S_RESULT;
        end else if (stat.empty) begin
          state_next = S_PLACE;
        end else begin
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        if (!stat.new_less) begin
          state_next = S_RESULT;
        end else if (stat.walk_last) begin
          state_next = S_PLACE;
        end
      end
      S_PLACE:    state_next = S_RESULT;
      S_POP_WAIT: state_next = S_RESULT;
      S_RESULT: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    req_ready = 1'b0;
    case (state)
      S_IDLE: begin
        req_ready    = 1'b1;
        cmd.latch_in = req_valid;
      end
      S_DECIDE: begin
        if (stat.is_pop) begin
          if (stat.empty) begin
            cmd.set_res  = 1'b1;
            cmd.res_code = RES_EMPTY;
          end else begin
            cmd.rd_head = 1'b1;
          end
        end else if (stat.full) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = RES_FULL;
        end else if (!stat.empty) begin
          cmd.rd_start = 1'b1;
        end
      end
      S_CMP: begin
        if (stat.new_less) begin
          cmd.shift = 1'b1;
        end else begin
          cmd.place    = 1'b1;
          cmd.set_res  = 1'b1;
          cmd.res_code = RES_INSERTED;
        end
      end
      S_PLACE: begin
        cmd.place    = 1'b1;
        cmd.set_res  = 1'b1;
        cmd.res_code = RES_INSERTED;
      end
      S_POP_WAIT: begin
        cmd.pop_take = 1'b1;
      end
      S_RESULT: begin
        cmd.load_out = stat.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ===== hw/rtl/eoq_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eoq_dpath
// Datapath for the ordered event queue: a circular entry memory with one
// write and one registered read port, head and count registers, the walk
// position, the tag comparator and the output register.
// ----------------------------------------------------------------------------
module eoq_dpath #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned TICK_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  eoq_pkg::eoq_req_t  req,
  input  eoq_pkg::eoq_cmd_t  cmd,
  output eoq_pkg::eoq_stat_t stat,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output eoq_pkg::eoq_rsp_t  rsp
);
  import eoq_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW:0] DEPTH_W = (AW + 1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  typedef struct packed {
    logic [7:0]            number;
    logic [TICK_WIDTH-1:0] deadline;
    logic [TICK_WIDTH-1:0] stamp;
    logic [11:0]           minor;
  } entry_t;

  entry_t        mem [DEPTH];
  entry_t        rdata;
  entry_t        new_entry;
  eoq_req_t      req_reg;
  eoq_rsp_t      res;
  eoq_rsp_t      rsp_load;
  logic [AW-1:0] head;
  logic [CW-1:0] count;
  logic [AW-1:0] walk;
  logic          rd_en;
  logic [AW-1:0] rd_idx;
  logic          wr_en;
  logic [AW-1:0] wr_idx;
  entry_t        wr_data;

  // Logical place to memory address, wrapping round the circular store.
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] hd, input logic [AW-1:0] idx);
    logic [AW:0] sum;
    sum = {1'b0, hd} + {1'b0, idx};
    if (sum >= DEPTH_W) sum = sum - DEPTH_W;
    return sum[AW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.latch_in) req_reg <= req;
  end

  always_comb begin
    new_entry.number   = req_reg.event_number;
    new_entry.deadline = TICK_WIDTH'(req_reg.deadline);
    new_entry.stamp    = TICK_WIDTH'(req_reg.stamp);
    new_entry.minor    = {req_reg.micro_step, req_reg.level};
  end

  // Read side: the tail at the start of a walk, two below the walk position
  // while shifting, so that the next compare has its data ready.
  always_comb begin
    rd_en  = cmd.rd_head | cmd.rd_start | cmd.shift;
    rd_idx = '0;
    if (cmd.rd_start) begin
      rd_idx = AW'(count - CW'(1));
    end else if (cmd.shift && (walk > AW'(1))) begin
      rd_idx = walk - AW'(2);
    end
  end

  always_comb begin
    wr_en   = cmd.shift | cmd.place;
    wr_idx  = walk;
    wr_data = cmd.shift ? rdata : new_entry;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rdata <= mem[phys(head, rd_idx)];
    if (wr_en) mem[phys(head, wr_idx)] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
      walk  <= '0;
    end else begin
      if (cmd.latch_in) begin
        walk <= '0;
      end else if (cmd.rd_start) begin
        walk <= AW'(count);
      end else if (cmd.shift) begin
        walk <= walk - AW'(1);
      end
      if (cmd.place) begin
        count <= count + CW'(1);
      end else if (cmd.pop_take) begin
        count <= count - CW'(1);
        head  <= (head == AW'(DEPTH - 1)) ? '0 : head + AW'(1);
      end
    end
  end

  // Result held until the output register is free.
  always_ff @(posedge clk) begin
    if (cmd.pop_take) begin
      res.status            <= RES_POPPED;
      res.head_event_number <= rdata.number;
      res.head_deadline     <= RspTickW'(rdata.deadline);
      res.head_stamp        <= RspTickW'(rdata.stamp);
      res.head_micro_step   <= rdata.minor[11:8];
      res.head_level        <= rdata.minor[7:0];
      res.occupancy         <= '0;
    end else if (cmd.set_res) begin
      res.status            <= cmd.res_code;
      res.head_event_number <= '0;
      res.head_deadline     <= '0;
      res.head_stamp        <= '0;
      res.head_micro_step   <= '0;
      res.head_level        <= '0;
      res.occupancy         <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load_out) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_comb begin
    rsp_load           = res;
    rsp_load.occupancy = 5'(count);
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      rsp <= rsp_load;
    end
  end

  always_comb begin
    stat.is_pop    = (req_reg.action == ACT_POP);
    stat.empty     = (count == '0);
    stat.full      = (count == DEPTH_C);
    stat.new_less  = {new_entry.deadline, new_entry.stamp, new_entry.minor}
                   < {rdata.deadline, rdata.stamp, rdata.minor};
    stat.walk_last = (walk == AW'(1));
    stat.out_free  = !rsp_valid || rsp_ready;
  end

endmodule

// ===== hw/rtl/edf_ordered_event_queue_unit.sv =====
`timescale 1ns / 1ps
// Sequence: a pop goes from decide through pop-wait to result; a pop on an
// empty queue or a dropped insert goes from decide straight to result; an
// insert walks past the stored entries with a larger tag, one per cycle, then
// places. One request at a time: the next waits until the result is loaded.
// Reset: synchronous; the queue comes up empty with no result pending.
// ----------------------------------------------------------------------------
// edf_ordered_event_queue_unit
// Earliest-deadline-first event queue, kept sorted by deadline, stamp,
// microstep and level, equal tags leaving in arrival order.
// ----------------------------------------------------------------------------
module edf_ordered_event_queue_unit #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned TICK_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  eoq_pkg::eoq_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output eoq_pkg::eoq_rsp_t rsp
);
  import eoq_pkg::*;

  eoq_cmd_t  cmd;
  eoq_stat_t stat;

  eoq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  eoq_dpath #(
    .DEPTH      (DEPTH),
    .TICK_WIDTH (TICK_WIDTH)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while another is in progress");

  a_no_place_when_full: assert property (@(posedge clk) disable iff (rst)
    cmd.place |-> !stat.full)
    else $error("entry written into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.pop_take |-> !stat.empty)
    else $error("head taken from an empty queue");

  a_load_only_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !rsp_valid || rsp_ready)
    else $error("output register overwritten before it was taken");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ordered event queue. A sorted list held in the
// bench mirrors the queue, so each accepted request yields the response that
// the hardware must return. Directed tests cover empty pops, tag ties at every
// key level, the field extremes and a full queue. Random traffic follows,
// with fill and drain phases and random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;
  import eoq_pkg::*;

  localparam int unsigned QUEUE_DEPTH  = 16;
  localparam int unsigned RANDOM_ITEMS = 400;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned SETTLE_CYCLES = 40;

  typedef struct packed {
    logic [31:0] deadline;
    logic [31:0] stamp;
    logic [3:0]  micro_step;
    logic [7:0]  level;
    logic [7:0]  event_number;
  } sched_entry_t;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     req_valid = 1'b0;
  logic     req_ready;
  eoq_req_t req = '0;
  logic     rsp_valid;
  logic     rsp_ready = 1'b0;
  eoq_rsp_t rsp;

  sched_entry_t sched_list[$];
  eoq_rsp_t     pending_rsp[$];
  int unsigned  mismatches = 0;
  int unsigned  cycle_count = 0;
  bit           sender_calm = 1'b0;
  logic         rsp_calm = 1'b0;
  int unsigned  ready_hold = 0;

  edf_ordered_event_queue_unit #(
    .DEPTH      (QUEUE_DEPTH),
    .TICK_WIDTH (32)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("edf_ordered_event_queue_unit: mismatch");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one, with calm stretches between.
  function automatic int unsigned idle_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Ties are made likely by drawing often from a handful of small values.
  function automatic logic [31:0] pick_tick();
    case ($urandom_range(0, 3))
      0, 1:    return 32'($urandom_range(0, 7));
      2:       return $urandom();
      default: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
    endcase
  endfunction

  function automatic eoq_req_t event_req(eoq_action_t act, logic [7:0] num,
                                         logic [31:0] dl, logic [31:0] st,
                                         logic [3:0] ms, logic [7:0] lv);
    eoq_req_t r;
    r.action       = act;
    r.event_number = num;
    r.deadline     = dl;
    r.stamp        = st;
    r.micro_step   = ms;
    r.level        = lv;
    return r;
  endfunction

  // Mirror of the queue: sorted insert behind every entry that is not
  // strictly larger, pop from the head.
  function automatic eoq_rsp_t queue_outcome(eoq_req_t r);
    eoq_rsp_t     res;
    sched_entry_t e;
    int           pos;
    res = '0;
    if (r.action == ACT_INSERT) begin
      if (sched_list.size() >= QUEUE_DEPTH) begin
        res.status = RES_FULL;
      end else begin
        e = '{r.deadline, r.stamp, r.micro_step, r.level, r.event_number};
        pos = sched_list.size();
        while (pos > 0 && {e.deadline, e.stamp, e.micro_step, e.level} <
               {sched_list[pos-1].deadline, sched_list[pos-1].stamp,
                sched_list[pos-1].micro_step, sched_list[pos-1].level})
          pos--;
        sched_list.insert(pos, e);
        res.status = RES_INSERTED;
      end
    end else if (sched_list.size() == 0) begin
      res.status = RES_EMPTY;
    end else begin
      e = sched_list.pop_front();
      res.status            = RES_POPPED;
      res.head_event_number = e.event_number;
      res.head_deadline     = e.deadline;
      res.head_stamp        = e.stamp;
      res.head_micro_step   = e.micro_step;
      res.head_level        = e.level;
    end
    res.occupancy = 5'(sched_list.size());
    return res;
  endfunction

  // Valid stays high after an item is taken until this task runs again, so a
  // back-to-back item never lowers and raises it within one time step.
  task automatic send_item(eoq_req_t item);
    int unsigned gap;
    gap = sender_calm ? 0 : idle_gap();
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req       <= item;
    req_valid <= 1'b1;
    do @(posedge clk); while (!(req_valid && req_ready));
    pending_rsp.push_back(queue_outcome(item));
  endtask

  // Always lets at least one edge pass, so valid is never driven twice at once.
  task automatic hold_until_drained();
    req_valid <= 1'b0;
    do @(posedge clk); while (pending_rsp.size() != 0);
  endtask

  always @(posedge clk) begin
    if ($urandom_range(0, 63) == 0) rsp_calm <= ~rsp_calm;
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
      rsp_ready  <= 1'b0;
    end else begin
      rsp_ready <= 1'b1;
      if (!rsp_calm && $urandom_range(0, 2) == 0) ready_hold <= idle_gap();
    end
  end

  function automatic void field_check(string name, logic [31:0] want,
                                      logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    eoq_rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_rsp.size() == 0) begin
        $display("%0t: response with none expected: %p", $time, rsp);
        mismatches++;
      end else begin
        want = pending_rsp.pop_front();
        field_check("status", 32'(want.status), 32'(rsp.status));
        field_check("head_event_number", 32'(want.head_event_number),
                    32'(rsp.head_event_number));
        field_check("head_deadline", want.head_deadline, rsp.head_deadline);
        field_check("head_stamp", want.head_stamp, rsp.head_stamp);
        field_check("head_micro_step", 32'(want.head_micro_step),
                    32'(rsp.head_micro_step));
        field_check("head_level", 32'(want.head_level), 32'(rsp.head_level));
        field_check("occupancy", 32'(want.occupancy), 32'(rsp.occupancy));
      end
    end
  end

  task automatic test_empty_pop();
    send_item(event_req(ACT_POP, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF, 8'hFF));
  endtask

  // The inserts are placed so that each key in turn, and full ties, decide positions.
  task automatic test_tag_order();
    send_item(event_req(ACT_INSERT, 8'h00, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF, 8'hFF));
    send_item(event_req(ACT_INSERT, 8'hFF, 32'h0, 32'h0, 4'h0, 8'h00));
    send_item(event_req(ACT_INSERT, 8'h01, 32'd100, 32'd5, 4'd3, 8'd7));
    send_item(event_req(ACT_INSERT, 8'h02, 32'd100, 32'd5, 4'd3, 8'd7));
    send_item(event_req(ACT_INSERT, 8'h03, 32'd100, 32'd5, 4'd3, 8'd6));
    send_item(event_req(ACT_INSERT, 8'h04, 32'd100, 32'd5, 4'd2, 8'd200));
    send_item(event_req(ACT_INSERT, 8'h05, 32'd100, 32'd4, 4'hF, 8'hFF));
    send_item(event_req(ACT_INSERT, 8'h06, 32'd99, 32'hFFFF_FFFF, 4'hF, 8'hFF));
    send_item(event_req(ACT_INSERT, 8'h07, 32'h0, 32'h0, 4'h0, 8'h00));
    send_item(event_req(ACT_INSERT, 8'hAA, 32'hAAAA_AAAA, 32'h5555_5555, 4'hA, 8'h55));
    send_item(event_req(ACT_INSERT, 8'h55, 32'h5555_5555, 32'hAAAA_AAAA, 4'h5, 8'hAA));
    send_item(event_req(ACT_INSERT, 8'h09, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF, 8'hFE));
    send_item(event_req(ACT_INSERT, 8'h0A, 32'd100, 32'd5, 4'd3, 8'd7));
    send_item(event_req(ACT_INSERT, 8'h80, 32'h8000_0000, 32'h1, 4'h8, 8'h80));
    send_item(event_req(ACT_INSERT, 8'h0C, 32'h1, 32'h0, 4'h0, 8'h00));
    send_item(event_req(ACT_INSERT, 8'h0D, 32'd100, 32'd6, 4'h0, 8'h00));
  endtask

  task automatic test_full_drop();
    send_item(event_req(ACT_INSERT, 8'h33, 32'h0, 32'h0, 4'h0, 8'h00));
  endtask

  // Pops part of the queue, then lets every response arrive before going on.
  task automatic test_head_order();
    repeat (7) send_item(event_req(ACT_POP, 8'h00, 32'h0, 32'h0, 4'h0, 8'h00));
    hold_until_drained();
  endtask

  // Phases lean towards inserts, towards pops or neither, so that the queue fills and empties.
  task automatic test_random_traffic();
    int unsigned sent;
    int unsigned phase_len;
    int unsigned insert_pct;
    int unsigned k;
    eoq_action_t act;
    logic [3:0]  ms;
    logic [7:0]  lv;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 2))
        0:       insert_pct = 85;
        1:       insert_pct = 50;
        default: insert_pct = 15;
      endcase
      phase_len   = $urandom_range(10, 40);
      sender_calm = ($urandom_range(0, 3) == 0);
      for (k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
        if ($urandom_range(0, 99) < insert_pct) act = ACT_INSERT;
        else act = ACT_POP;
        ms = $urandom_range(0, 1) ? 4'($urandom_range(0, 1)) : 4'($urandom_range(0, 15));
        lv = $urandom_range(0, 1) ? 8'($urandom_range(0, 1)) : 8'($urandom_range(0, 255));
        send_item(event_req(act, 8'($urandom_range(0, 255)), pick_tick(), pick_tick(),
                            ms, lv));
        sent++;
      end
      if ($urandom_range(0, 3) == 0) hold_until_drained();
    end
    sender_calm = 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_pop();
    test_tag_order();
    test_full_drop();
    test_head_order();
    test_random_traffic();
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("edf_ordered_event_queue_unit: match");
    else
      $display("edf_ordered_event_queue_unit: mismatch");
    $finish;
  end

endmodule
